### src/edge_point_sampler_unit_macros.svh
`ifndef EDGE_POINT_SAMPLER_UNIT_MACROS_SVH
`define EDGE_POINT_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define EPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/eps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eps_pkg;

   localparam int COORD_W = 16;
   localparam int DENS_W  = 6;
   localparam int DIM_W   = 10;
   localparam int DELTA_W = COORD_W + 1;
   localparam int AXES    = 3;
   localparam int NUM_W   = 27;
   localparam int DIVS_W  = 11;
   localparam int DIVC_W  = 5;
   localparam int MUL_W   = 44;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 44;
   localparam int VEC_W   = 24;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_DENSITY   = 3'd0;
   localparam reg_idx_type REG_OCCLUSION = 3'd1;
   localparam reg_idx_type REG_WIDTH     = 3'd2;
   localparam reg_idx_type REG_HEIGHT    = 3'd3;
   localparam reg_idx_type REG_CENTER_X  = 3'd4;
   localparam reg_idx_type REG_CENTER_Y  = 3'd5;
   localparam reg_idx_type REG_CENTER_Z  = 3'd6;

   localparam logic signed [VEC_W-1:0] COP_Z   = 24'sd2560000;
   localparam logic [NUM_W-1:0]        COL_OFF = 27'd320;
   localparam logic [NUM_W-1:0]        ROW_OFF = 27'd640;

   // 640 = 5 << 7 and 1280 = 5 << 8: shift, then multiply by the reciprocal of 5
   localparam int               COL_SHIFT   = 7;
   localparam int               ROW_SHIFT   = 8;
   localparam int               RECIP_SHIFT = 22;
   // ceil(2^22 / 5), exact for every shifted numerator below 2^22
   localparam logic [MUL_W-1:0] RECIP5      = 44'd838861;

   localparam logic [COORD_W-1:0] MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] MIN_NEG = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_col;
      logic signed [COORD_W-1:0] screen_row;
      logic                      far_side;
      logic                      visible;
      logic                      last;
   } rsp_type;

   // sign and magnitude quotient to a saturated screen coordinate
   function automatic logic [COORD_W-1:0] sat_quot(input logic neg,
                                                   input logic [NUM_W-1:0] q);
      logic [COORD_W-1:0] r;
      if (!neg) begin
         if (q > NUM_W'(MAX_POS)) r = MAX_POS;
         else r = q[COORD_W-1:0];
      end else begin
         if (q > NUM_W'(MIN_NEG)) r = MIN_NEG;
         else r = COORD_W'(0) - q[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/edge_point_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// one request at a time: ready only while idle; with non-zero density the set-up is three
// divisions (per-axis step by the density) after the request is taken; each sample then
// takes two shift-add multiplies by the height and two reciprocal multiplies for /640 and
// /1280; occlusion adds up to eleven multiplies; an edge is the set-up plus density+1
// samples; synchronous reset loads defaults, sequencer to idle, no clearing

`include "edge_point_sampler_unit_macros.svh"

module edge_point_sampler_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  eps_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output eps_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [eps_pkg::ADDR_W-1:0]   paddr,
   input  logic [eps_pkg::DATA_W-1:0]   pwdata,
   output logic [eps_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import eps_pkg::*;

   localparam int PSUM_W = COORD_W + 2;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIV   = 9'b000000010,
      ST_POINT = 9'b000000100,
      ST_MCOL  = 9'b000001000,
      ST_DCOL  = 9'b000010000,
      ST_MROW  = 9'b000100000,
      ST_DROW  = 9'b001000000,
      ST_OCC   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // occlusion multiply steps: dot terms, |a|^2 terms, |b|^2 terms, final pair
   typedef enum logic [3:0] {
      OP_AXBX, OP_AYBY, OP_AZBZ,
      OP_AXAX, OP_AYAY, OP_AZAZ,
      OP_BXBX, OP_BYBY, OP_BZBZ,
      OP_DSQ,  OP_PROD
   } op_type;

   // configuration registers
   logic [DENS_W-1:0]         density_ff, density_in;
   logic                      occ_en_ff, occ_en_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   // sequencer and edge state
   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [1:0]                comp_ff, comp_in;
   logic [DENS_W-1:0]         k_ff, k_in;
   logic                      mlaunch_ff, mlaunch_in;
   logic                      dlaunch_ff, dlaunch_in;

   logic signed [COORD_W-1:0] start_ff [AXES];
   logic signed [COORD_W-1:0] start_in [AXES];
   logic [DELTA_W-1:0]        dmag_ff [AXES];
   logic [DELTA_W-1:0]        dmag_in [AXES];
   logic                      dneg_ff [AXES];
   logic                      dneg_in [AXES];
   logic [DELTA_W-1:0]        q0_ff [AXES];
   logic [DELTA_W-1:0]        q0_in [AXES];
   logic [DENS_W-1:0]         r0_ff [AXES];
   logic [DENS_W-1:0]         r0_in [AXES];
   logic [DELTA_W-1:0]        q_ff [AXES];
   logic [DELTA_W-1:0]        q_in [AXES];
   logic [DENS_W-1:0]         r_ff [AXES];
   logic [DENS_W-1:0]         r_in [AXES];
   logic signed [COORD_W-1:0] p_ff [AXES];
   logic signed [COORD_W-1:0] p_in [AXES];

   logic [NUM_W-1:0]          nmag_ff, nmag_in;
   logic                      nneg_ff, nneg_in;
   logic [COORD_W-1:0]        col_ff, col_in, row_ff, row_in;
   logic signed [ACC_W-1:0]   dot_ff, dot_in;
   logic [ACC_W-1:0]          ma_ff, ma_in, mb_ff, mb_in;
   logic [PROD_W-1:0]         dsq_ff, dsq_in;
   rsp_type                   rsp_ff, rsp_in;

   // shared units
   logic                      mul_done, div_done;
   logic [MUL_W-1:0]          mcand, mplier;
   logic [PROD_W-1:0]         product;
   logic [NUM_W-1:0]          dividend, quotient;
   logic [DIVS_W-1:0]         divisor, remainder;
   logic                      op_neg;

   // occlusion vectors from the current sample
   logic signed [DELTA_W-1:0] ax, ay, az, bx, by;
   logic signed [VEC_W-1:0]   bz;
   logic [DELTA_W-1:0]        axm, aym, azm, bxm, bym;
   logic [VEC_W-1:0]          bzm;

   logic signed [COORD_W-1:0] req_s [AXES];
   logic signed [COORD_W-1:0] req_e [AXES];
   logic                      csr_wr;
   reg_idx_type               csr_idx;

   assign req_s[0] = req_data.start_x;
   assign req_s[1] = req_data.start_y;
   assign req_s[2] = req_data.start_z;
   assign req_e[0] = req_data.end_x;
   assign req_e[1] = req_data.end_y;
   assign req_e[2] = req_data.end_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_idx   = paddr[ADDR_W-1:2];

   // register file: writes must land only while idle; the block itself does not guard them
   always_comb begin
      density_in = density_ff;
      occ_en_in  = occ_en_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_DENSITY:   density_in = pwdata[DENS_W-1:0];
            REG_OCCLUSION: occ_en_in  = pwdata[0];
            REG_WIDTH:     width_in   = pwdata[DIM_W-1:0];
            REG_HEIGHT:    height_in  = pwdata[DIM_W-1:0];
            REG_CENTER_X:  cx_in      = pwdata[COORD_W-1:0];
            REG_CENTER_Y:  cy_in      = pwdata[COORD_W-1:0];
            REG_CENTER_Z:  cz_in      = pwdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DENSITY:   prdata = DATA_W'(density_ff);
         REG_OCCLUSION: prdata = DATA_W'(occ_en_ff);
         REG_WIDTH:     prdata = DATA_W'(width_ff);
         REG_HEIGHT:    prdata = DATA_W'(height_ff);
         REG_CENTER_X:  prdata = DATA_W'(cx_ff);
         REG_CENTER_Y:  prdata = DATA_W'(cy_ff);
         REG_CENTER_Z:  prdata = DATA_W'(cz_ff);
         default:       prdata = '0;
      endcase
   end

   // a = centre - p, b = projection centre - p
   always_comb begin
      ax  = DELTA_W'(cx_ff) - DELTA_W'(p_ff[0]);
      ay  = DELTA_W'(cy_ff) - DELTA_W'(p_ff[1]);
      az  = DELTA_W'(cz_ff) - DELTA_W'(p_ff[2]);
      bx  = DELTA_W'(0) - DELTA_W'(p_ff[0]);
      by  = DELTA_W'(0) - DELTA_W'(p_ff[1]);
      bz  = COP_Z - VEC_W'(p_ff[2]);
      axm = ax[DELTA_W-1] ? DELTA_W'(-ax) : DELTA_W'(ax);
      aym = ay[DELTA_W-1] ? DELTA_W'(-ay) : DELTA_W'(ay);
      azm = az[DELTA_W-1] ? DELTA_W'(-az) : DELTA_W'(az);
      bxm = bx[DELTA_W-1] ? DELTA_W'(-bx) : DELTA_W'(bx);
      bym = by[DELTA_W-1] ? DELTA_W'(-by) : DELTA_W'(by);
      bzm = bz[VEC_W-1] ? VEC_W'(-bz) : VEC_W'(bz);
   end

   // operand select for the shared multiplier
   always_comb begin
      mcand  = '0;
      mplier = '0;
      op_neg = 1'b0;
      case (state_ff)
         ST_MCOL: begin
            mcand  = p_ff[0][COORD_W-1] ? MUL_W'(-p_ff[0]) : MUL_W'(p_ff[0]);
            mcand  = MUL_W'(mcand[COORD_W-1:0]);
            mplier = MUL_W'(height_ff);
         end
         ST_DCOL: begin
            // divide by 640: drop 7 bits, then reciprocal of 5
            mcand  = MUL_W'(nmag_ff >> COL_SHIFT);
            mplier = RECIP5;
         end
         ST_MROW: begin
            mcand  = p_ff[1][COORD_W-1] ? MUL_W'(-p_ff[1]) : MUL_W'(p_ff[1]);
            mcand  = MUL_W'(mcand[COORD_W-1:0]);
            mplier = MUL_W'(height_ff);
         end
         ST_DROW: begin
            // divide by 1280: drop 8 bits, then reciprocal of 5
            mcand  = MUL_W'(nmag_ff >> ROW_SHIFT);
            mplier = RECIP5;
         end
         ST_OCC: begin
            case (op_ff)
               OP_AXBX: begin
                  mcand = MUL_W'(axm); mplier = MUL_W'(bxm);
                  op_neg = ax[DELTA_W-1] ^ bx[DELTA_W-1];
               end
               OP_AYBY: begin
                  mcand = MUL_W'(aym); mplier = MUL_W'(bym);
                  op_neg = ay[DELTA_W-1] ^ by[DELTA_W-1];
               end
               OP_AZBZ: begin
                  mcand = MUL_W'(bzm); mplier = MUL_W'(azm);
                  op_neg = az[DELTA_W-1] ^ bz[VEC_W-1];
               end
               OP_AXAX: begin mcand = MUL_W'(axm); mplier = MUL_W'(axm); end
               OP_AYAY: begin mcand = MUL_W'(aym); mplier = MUL_W'(aym); end
               OP_AZAZ: begin mcand = MUL_W'(azm); mplier = MUL_W'(azm); end
               OP_BXBX: begin mcand = MUL_W'(bxm); mplier = MUL_W'(bxm); end
               OP_BYBY: begin mcand = MUL_W'(bym); mplier = MUL_W'(bym); end
               OP_BZBZ: begin mcand = MUL_W'(bzm); mplier = MUL_W'(bzm); end
               OP_DSQ:  begin mcand = MUL_W'(dot_ff); mplier = MUL_W'(dot_ff); end
               OP_PROD: begin mcand = mb_ff; mplier = ma_ff; end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // divider operands: per-axis step by the density
   always_comb begin
      dividend = NUM_W'(dmag_ff[comp_ff]);
      divisor  = DIVS_W'(density_ff);
   end

   eps_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mlaunch_ff),
      .mcand   (mcand),
      .mplier  (mplier),
      .done    (mul_done),
      .product (product)
   );

   eps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dlaunch_ff),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // sequencer
   always_comb begin
      logic signed [DELTA_W-1:0] dl;
      logic signed [PSUM_W-1:0]  ps;
      logic signed [PSUM_W-1:0]  qs;
      logic signed [NUM_W-1:0]   pterm;
      logic signed [NUM_W-1:0]   num;
      logic [NUM_W-1:0]          offs;
      logic [ACC_W-1:0]          term;
      logic [DENS_W:0]           rs;
      logic                      finish;
      logic                      vis;

      state_in   = state_ff;
      op_in      = op_ff;
      comp_in    = comp_ff;
      k_in       = k_ff;
      mlaunch_in = 1'b0;
      dlaunch_in = 1'b0;
      start_in   = start_ff;
      dmag_in    = dmag_ff;
      dneg_in    = dneg_ff;
      q0_in      = q0_ff;
      r0_in      = r0_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      p_in       = p_ff;
      nmag_in    = nmag_ff;
      nneg_in    = nneg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      dot_in     = dot_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      dsq_in     = dsq_ff;
      rsp_in     = rsp_ff;
      finish     = 1'b0;
      vis        = 1'b1;
      dl         = '0;
      ps         = '0;
      qs         = '0;
      num        = '0;
      offs       = '0;
      rs         = '0;
      term       = product[ACC_W-1:0];
      pterm      = signed'({1'b0, product[NUM_W-2:0]});

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < AXES; i++) begin
                  dl          = DELTA_W'(req_e[i]) - DELTA_W'(req_s[i]);
                  start_in[i] = req_s[i];
                  dneg_in[i]  = dl[DELTA_W-1];
                  dmag_in[i]  = dl[DELTA_W-1] ? DELTA_W'(-dl) : DELTA_W'(dl);
                  q_in[i]     = '0;
                  r_in[i]     = '0;
                  q0_in[i]    = '0;
                  r0_in[i]    = '0;
               end
               k_in    = '0;
               comp_in = '0;
               if (density_ff == '0) begin
                  state_in = ST_POINT;
               end else begin
                  state_in   = ST_DIV;
                  dlaunch_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               q0_in[comp_ff] = quotient[DELTA_W-1:0];
               r0_in[comp_ff] = remainder[DENS_W-1:0];
               if (comp_ff == 2'(AXES - 1)) begin
                  state_in = ST_POINT;
               end else begin
                  comp_in    = comp_ff + 1'b1;
                  dlaunch_in = 1'b1;
               end
            end
         end
         ST_POINT: begin
            // start point plus the signed running step total
            for (int i = 0; i < AXES; i++) begin
               qs      = signed'(PSUM_W'(q_ff[i]));
               ps      = PSUM_W'(start_ff[i]) + (dneg_ff[i] ? -qs : qs);
               p_in[i] = ps[COORD_W-1:0];
            end
            state_in   = ST_MCOL;
            mlaunch_in = 1'b1;
         end
         ST_MCOL: begin
            if (mul_done) begin
               offs    = NUM_W'(width_ff) * COL_OFF;
               num     = (p_ff[0][COORD_W-1] ? -pterm : pterm) + signed'(offs);
               nneg_in = num[NUM_W-1];
               nmag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
               state_in   = ST_DCOL;
               mlaunch_in = 1'b1;
            end
         end
         ST_DCOL: begin
            if (mul_done) begin
               col_in     = sat_quot(nneg_ff, product[RECIP_SHIFT +: NUM_W]);
               state_in   = ST_MROW;
               mlaunch_in = 1'b1;
            end
         end
         ST_MROW: begin
            if (mul_done) begin
               offs    = NUM_W'(height_ff) * ROW_OFF;
               num     = signed'(offs) - (p_ff[1][COORD_W-1] ? -pterm : pterm);
               nneg_in = num[NUM_W-1];
               nmag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
               state_in   = ST_DROW;
               mlaunch_in = 1'b1;
            end
         end
         ST_DROW: begin
            if (mul_done) begin
               row_in = sat_quot(nneg_ff, product[RECIP_SHIFT +: NUM_W]);
               if (occ_en_ff) begin
                  state_in   = ST_OCC;
                  op_in      = OP_AXBX;
                  mlaunch_in = 1'b1;
                  dot_in     = '0;
                  ma_in      = '0;
                  mb_in      = '0;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ST_OCC: begin
            if (mul_done) begin
               mlaunch_in = 1'b1;
               op_in      = op_type'(op_ff + 1'b1);
               case (op_ff)
                  OP_AXBX, OP_AYBY, OP_AZBZ: begin
                     dot_in = dot_ff + signed'(op_neg ? ACC_W'(-term) : term);
                  end
                  OP_AXAX, OP_AYAY, OP_AZAZ: begin
                     ma_in = ma_ff + term;
                  end
                  OP_BXBX, OP_BYBY: begin
                     mb_in = mb_ff + term;
                  end
                  OP_BZBZ: begin
                     mb_in = mb_ff + term;
                     // non-positive dot: angle at least a right angle
                     if (dot_ff[ACC_W-1] || (dot_ff == '0)) begin
                        mlaunch_in = 1'b0;
                        finish     = 1'b1;
                     end
                  end
                  OP_DSQ: begin
                     dsq_in = product;
                  end
                  OP_PROD: begin
                     mlaunch_in = 1'b0;
                     finish     = 1'b1;
                     vis        = !({dsq_ff, 2'b00} > {2'b00, product});
                  end
                  default: begin
                     mlaunch_in = 1'b0;
                     finish     = 1'b1;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (rsp_ff.last) begin
                  state_in = ST_IDLE;
                  k_in     = '0;
               end else begin
                  // step each axis by quotient and carry its remainder
                  k_in = k_ff + 1'b1;
                  for (int i = 0; i < AXES; i++) begin
                     rs = {1'b0, r_ff[i]} + {1'b0, r0_ff[i]};
                     if (rs >= {1'b0, density_ff}) begin
                        r_in[i] = DENS_W'(rs - {1'b0, density_ff});
                        q_in[i] = q_ff[i] + q0_ff[i] + 1'b1;
                     end else begin
                        r_in[i] = rs[DENS_W-1:0];
                        q_in[i] = q_ff[i] + q0_ff[i];
                     end
                  end
                  state_in = ST_POINT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_in.screen_col = col_ff;
         rsp_in.screen_row = row_in;
         rsp_in.far_side   = p_ff[2][COORD_W-1];
         rsp_in.visible    = vis;
         rsp_in.last       = (k_ff >= density_ff);
         state_in          = ST_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENS_W'(50);
         occ_en_ff  <= 1'b0;
         width_ff   <= DIM_W'(80);
         height_ff  <= DIM_W'(24);
         cx_ff      <= '0;
         cy_ff      <= '0;
         cz_ff      <= '0;
         state_ff   <= ST_IDLE;
         op_ff      <= OP_AXBX;
         comp_ff    <= '0;
         k_ff       <= '0;
         mlaunch_ff <= 1'b0;
         dlaunch_ff <= 1'b0;
      end else begin
         density_ff <= density_in;
         occ_en_ff  <= occ_en_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         cz_ff      <= cz_in;
         state_ff   <= state_in;
         op_ff      <= op_in;
         comp_ff    <= comp_in;
         k_ff       <= k_in;
         mlaunch_ff <= mlaunch_in;
         dlaunch_ff <= dlaunch_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      q0_ff    <= q0_in;
      r0_ff    <= r0_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      p_ff     <= p_in;
      nmag_ff  <= nmag_in;
      nneg_ff  <= nneg_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      dot_ff   <= dot_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      dsq_ff   <= dsq_in;
      rsp_ff   <= rsp_in;
   end

   `EPS_ASSERT_NEXT(a_last_frees_input, rsp_valid && rsp_ready && rsp_data.last, req_ready, "busy")
   `EPS_ASSERT_NEXT(a_request_blocks, req_valid && req_ready, !req_ready, "second request taken")
   `EPS_ASSERT_IMPL(a_mul_done_owner, mul_done, !req_ready && !rsp_valid, "stray product")
   `EPS_ASSERT_IMPL(a_div_done_owner, div_done, state_ff == ST_DIV, "stray quotient")
   `EPS_ASSERT_IMPL(a_index_bound, !req_ready, k_ff <= density_ff, "sample index past the density")

endmodule

`default_nettype wire

### src/eps_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module eps_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [eps_pkg::MUL_W-1:0]   mcand,
   input  logic [eps_pkg::MUL_W-1:0]   mplier,
   output logic                        done,
   output logic [eps_pkg::PROD_W-1:0]  product
);
   import eps_pkg::*;

   logic              run_ff, run_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] sh_ff, sh_in;
   logic [MUL_W-1:0]  mp_ff, mp_in;

   // shift-add, stops once the multiplier bits run out
   always_comb begin
      run_in = run_ff;
      acc_in = acc_ff;
      sh_in  = sh_ff;
      mp_in  = mp_ff;
      done   = run_ff && (mp_ff == '0);
      if (start) begin
         run_in = 1'b1;
         acc_in = '0;
         sh_in  = PROD_W'(mcand);
         mp_in  = mplier;
      end else if (run_ff) begin
         if (done) begin
            run_in = 1'b0;
         end else begin
            if (mp_ff[0]) acc_in = acc_ff + sh_ff;
            sh_in = sh_ff << 1;
            mp_in = mp_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mp_ff  <= mp_in;
   end

   assign product = acc_ff;

endmodule

`default_nettype wire

### src/eps_div.sv
`timescale 1ns / 1ps
`default_nettype none

module eps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [eps_pkg::NUM_W-1:0]   dividend,
   input  logic [eps_pkg::DIVS_W-1:0]  divisor,
   output logic                        done,
   output logic [eps_pkg::NUM_W-1:0]   quotient,
   output logic [eps_pkg::DIVS_W-1:0]  remainder
);
   import eps_pkg::*;

   logic              run_ff, run_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVS_W:0]   trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      done   = run_ff && (cnt_ff == '0);
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIVC_W'(NUM_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (done) begin
            run_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in = DIVS_W'(trial - {1'b0, dsr_ff});
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIVS_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
